[sv/fac_pkg.sv]
package fac_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 32;
  localparam logic [16:0] POOL_LIMIT = 17'd65536;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] OP_FIRST = 2'd0;
  localparam logic [1:0] OP_BEST  = 2'd1;
  localparam logic [1:0] OP_WORST = 2'd2;
  localparam logic [1:0] OP_FREE  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_BADADDR = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [16:0] request_bytes;
    logic [31:0] release_address;
  } fac_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [16:0] bytes_in_use;
    logic [16:0] bytes_remaining;
    logic [5:0]  free_segments;
    logic [31:0] grant_count;
  } fac_rsp_t;

  typedef struct packed {
    logic [15:0] off;
    logic [16:0] len;
    logic        fr;
  } fac_seg_t;

endpackage

[sv/fit_allocator_with_coalescing.sv]
// A request is taken in S_IDLE, S_SCAN reads the segment table entry by entry, S_DECIDE
// picks the result and S_DONE loads it into the output register, waiting while out_stall_i
// holds a previous result. When the table changes (a split, an exact fit or a free merge),
// S_SHIFT first moves the entries behind the change and S_WR then makes one or two table writes.
// One request is in work at a time; the next is taken in S_IDLE, after the result is loaded.
// Reset and any register write rebuild entry 0 in one cycle before the next request.
module fit_allocator_with_coalescing
  import fac_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fac_req_t             in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fac_rsp_t             out_rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WR, S_DONE
  } state_e;

  state_e state_q;

  logic [31:0] base_q;
  logic [16:0] size_q;
  logic [CW-1:0] used_q, free_cnt_q;
  logic [16:0] alloc_q;
  logic [31:0] succ_q;

  fac_req_t req_q;
  logic [CW-1:0] iss_q;
  logic rv_q;
  logic [IW-1:0] ridx_q;
  logic found_q, pfree_q, nfree_q, want_next_q;
  logic [IW-1:0] pick_q;
  logic [16:0] plen_q, prevlen_q, nlen_q;
  logic [15:0] poff_q, prevoff_q;
  fac_seg_t lst_q;

  logic [2:0] st_q;
  logic [31:0] gaddr_q;

  logic sh_up_q, pend_q;
  logic [1:0] sh_k_q;
  logic [IW-1:0] sh_src_q, pend_dst_q;
  logic [CW-1:0] sh_cnt_q;
  logic [IW-1:0] w1_addr_q, w2_addr_q;
  fac_seg_t w1_q, w2_q;
  logic w2v_q, wph_q;

  logic out_valid_q;
  fac_rsp_t out_rsp_q;

  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  fac_seg_t ram_wdata, rd;

  logic cfg_take, out_load;

  fac_ram #(.W($bits(fac_seg_t)), .D(MAX_SEGMENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  logic is_free_op, split, cand, better, hit;
  logic [2:0] st_d;
  logic [16:0] size_d;
  logic [CW-1:0] s_down;

  assign cfg_take = cfg_we_i && ((cfg_idx_i == CFG_POOL_BASE) || (cfg_idx_i == CFG_POOL_SIZE));
  assign out_load = (state_q == S_DONE) && !cfg_take && (!out_valid_q || !out_stall_i);

  always_comb begin
    is_free_op = (req_q.opcode == OP_FREE);
    split = (plen_q > req_q.request_bytes);
    if (is_free_op) begin
      st_d = found_q ? ST_OK : ST_BADADDR;
    end else if (req_q.request_bytes == 17'd0) begin
      st_d = ST_ZERO;
    end else if (!found_q) begin
      st_d = ST_NOFIT;
    end else if (split && (used_q >= CW'(MAX_SEGMENTS))) begin
      st_d = ST_FULL;
    end else begin
      st_d = ST_OK;
    end
    cand = rd.fr && (rd.len >= req_q.request_bytes);
    better = !found_q || ((req_q.opcode == OP_BEST) && (rd.len < plen_q)) ||
             ((req_q.opcode == OP_WORST) && (rd.len > plen_q));
    hit = !found_q && !rd.fr && ((base_q + {16'd0, rd.off}) == req_q.release_address);
    s_down = CW'(pick_q) + CW'(1) + CW'(nfree_q);
    size_d = cfg_data_i[16:0];
    if (size_d == 17'd0) begin
      size_d = 17'd1;
    end else if (size_d > POOL_LIMIT) begin
      size_d = POOL_LIMIT;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = w1_q;
    ram_raddr = '0;
    case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
        ram_wdata = '{off: 16'd0, len: size_q, fr: 1'b1};
      end
      S_SCAN: begin
        ram_raddr = iss_q[IW-1:0];
      end
      S_SHIFT: begin
        ram_raddr = sh_src_q;
        ram_we = pend_q;
        ram_waddr = pend_dst_q;
        ram_wdata = rd;
      end
      S_WR: begin
        ram_we = 1'b1;
        ram_waddr = wph_q ? w2_addr_q : w1_addr_q;
        ram_wdata = wph_q ? w2_q : w1_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      base_q <= 32'd0;
      size_q <= POOL_LIMIT;
      used_q <= CW'(1);
      free_cnt_q <= CW'(1);
      alloc_q <= 17'd0;
      succ_q <= 32'd0;
      out_valid_q <= 1'b0;
      rv_q <= 1'b0;
      pend_q <= 1'b0;
      wph_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_take) begin
        if (cfg_idx_i == CFG_POOL_BASE) begin
          base_q <= cfg_data_i;
        end else begin
          size_q <= size_d;
        end
        used_q <= CW'(1);
        free_cnt_q <= CW'(1);
        alloc_q <= 17'd0;
        succ_q <= 32'd0;
        state_q <= S_INIT;
      end else begin
        case (state_q)
          S_INIT: begin
            state_q <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid_i) begin
              req_q <= in_req_i;
              iss_q <= '0;
              rv_q <= 1'b0;
              found_q <= 1'b0;
              pfree_q <= 1'b0;
              nfree_q <= 1'b0;
              want_next_q <= 1'b0;
              plen_q <= 17'd0;
              lst_q <= '0;
              state_q <= S_SCAN;
            end
          end
          S_SCAN: begin
            rv_q <= (iss_q < used_q);
            ridx_q <= iss_q[IW-1:0];
            if (iss_q < used_q) begin
              iss_q <= iss_q + CW'(1);
            end
            if (rv_q) begin
              lst_q <= rd;
              if (!is_free_op) begin
                if (cand && better) begin
                  found_q <= 1'b1;
                  pick_q <= ridx_q;
                  plen_q <= rd.len;
                  poff_q <= rd.off;
                end
              end else begin
                if (want_next_q) begin
                  nfree_q <= rd.fr;
                  nlen_q <= rd.len;
                  want_next_q <= 1'b0;
                end
                if (hit) begin
                  found_q <= 1'b1;
                  pick_q <= ridx_q;
                  plen_q <= rd.len;
                  poff_q <= rd.off;
                  pfree_q <= (ridx_q != '0) && lst_q.fr;
                  prevoff_q <= lst_q.off;
                  prevlen_q <= lst_q.len;
                  want_next_q <= 1'b1;
                end
              end
              if (CW'(ridx_q) == used_q - CW'(1)) begin
                state_q <= S_DECIDE;
              end
            end
          end
          S_DECIDE: begin
            st_q <= st_d;
            gaddr_q <= (!is_free_op && (st_d == ST_OK)) ? base_q + {16'd0, poff_q} : 32'd0;
            pend_q <= 1'b0;
            wph_q <= 1'b0;
            if (st_d != ST_OK) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_SHIFT;
              if (!is_free_op) begin
                alloc_q <= alloc_q + req_q.request_bytes;
                succ_q <= succ_q + 32'd1;
                sh_up_q <= 1'b1;
                sh_k_q <= 2'd1;
                if (split) begin
                  used_q <= used_q + CW'(1);
                  sh_src_q <= IW'(used_q - CW'(1));
                  sh_cnt_q <= used_q - CW'(pick_q) - CW'(1);
                  w1_addr_q <= pick_q + IW'(1);
                  w1_q <= '{off: poff_q + req_q.request_bytes[15:0],
                            len: plen_q - req_q.request_bytes, fr: 1'b1};
                  w2v_q <= 1'b1;
                  w2_addr_q <= pick_q;
                  w2_q <= '{off: poff_q, len: req_q.request_bytes, fr: 1'b0};
                end else begin
                  free_cnt_q <= free_cnt_q - CW'(1);
                  sh_cnt_q <= '0;
                  w1_addr_q <= pick_q;
                  w1_q <= '{off: poff_q, len: plen_q, fr: 1'b0};
                  w2v_q <= 1'b0;
                end
              end else begin
                alloc_q <= (alloc_q >= plen_q) ? alloc_q - plen_q : 17'd0;
                free_cnt_q <= free_cnt_q + CW'(1) - CW'(pfree_q) - CW'(nfree_q);
                used_q <= used_q - CW'(pfree_q) - CW'(nfree_q);
                sh_up_q <= 1'b0;
                sh_k_q <= {1'b0, pfree_q} + {1'b0, nfree_q};
                sh_src_q <= IW'(s_down);
                sh_cnt_q <= used_q - s_down;
                w1_addr_q <= pfree_q ? pick_q - IW'(1) : pick_q;
                w1_q <= '{off: pfree_q ? prevoff_q : poff_q,
                          len: plen_q + (pfree_q ? prevlen_q : 17'd0) +
                               (nfree_q ? nlen_q : 17'd0),
                          fr: 1'b1};
                w2v_q <= 1'b0;
              end
            end
          end
          S_SHIFT: begin
            if (sh_cnt_q != '0) begin
              pend_q <= 1'b1;
              pend_dst_q <= sh_up_q ? sh_src_q + IW'(1) : sh_src_q - IW'(sh_k_q);
              sh_src_q <= sh_up_q ? sh_src_q - IW'(1) : sh_src_q + IW'(1);
              sh_cnt_q <= sh_cnt_q - CW'(1);
            end else begin
              pend_q <= 1'b0;
              state_q <= S_WR;
            end
          end
          S_WR: begin
            if (!wph_q && w2v_q) begin
              wph_q <= 1'b1;
            end else begin
              state_q <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_load) begin
              out_rsp_q.status <= st_q;
              out_rsp_q.granted_address <= gaddr_q;
              out_rsp_q.bytes_in_use <= alloc_q;
              out_rsp_q.bytes_remaining <= (size_q >= alloc_q) ? size_q - alloc_q : 17'd0;
              out_rsp_q.free_segments <= 6'(free_cnt_q);
              out_rsp_q.grant_count <= succ_q;
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_INIT;
        endcase
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o = out_rsp_q;

endmodule

[sv/fac_ram.sv]
module fac_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[dv/fac_checker.sv]
`timescale 1ns / 100ps

module fac_checker
  import fac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  fac_req_t    in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  fac_rsp_t    out_rsp_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int NSEG = 32;

  logic [31:0] base_q;
  logic [16:0] size_q;
  logic [15:0] off_q [NSEG];
  logic [16:0] len_q [NSEG];
  logic        fr_q  [NSEG];
  int          used_q;
  logic [16:0] alloc_q;
  logic [31:0] grants_q;
  fac_rsp_t    rsp_fifo [$];

  function automatic void pool_clear();
    used_q = 1;
    off_q[0] = '0;
    len_q[0] = size_q;
    fr_q[0] = 1'b1;
    alloc_q = '0;
    grants_q = '0;
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < used_q; i++) begin
      off_q[i] = off_q[i+1];
      len_q[i] = len_q[i+1];
      fr_q[i] = fr_q[i+1];
    end
    used_q--;
  endfunction

  function automatic fac_rsp_t alloc_outcome(fac_req_t rq);
    fac_rsp_t r;
    int pick;
    int nfree;
    bit found;
    logic [16:0] req;
    r = '0;
    req = rq.request_bytes;
    pick = 0;
    found = 0;
    if (rq.opcode != OP_FREE) begin
      if (req == 0) begin
        r.status = ST_ZERO;
      end else begin
        for (int i = 0; i < used_q; i++) begin
          if (fr_q[i] && len_q[i] >= req) begin
            if (!found || (rq.opcode == OP_BEST && len_q[i] < len_q[pick]) ||
                (rq.opcode == OP_WORST && len_q[i] > len_q[pick])) begin
              pick = i;
              found = 1;
            end
            if (rq.opcode == OP_FIRST) break;
          end
        end
        if (!found) begin
          r.status = ST_NOFIT;
        end else if (len_q[pick] > req && used_q >= NSEG) begin
          r.status = ST_FULL;
        end else begin
          if (len_q[pick] > req) begin
            for (int i = used_q; i > pick + 1; i--) begin
              off_q[i] = off_q[i-1];
              len_q[i] = len_q[i-1];
              fr_q[i] = fr_q[i-1];
            end
            off_q[pick+1] = off_q[pick] + req[15:0];
            len_q[pick+1] = len_q[pick] - req;
            fr_q[pick+1] = 1'b1;
            used_q++;
            len_q[pick] = req;
          end
          fr_q[pick] = 1'b0;
          alloc_q = alloc_q + req;
          grants_q = grants_q + 1;
          r.status = ST_OK;
          r.granted_address = base_q + {16'd0, off_q[pick]};
        end
      end
    end else begin
      for (int i = 0; i < used_q; i++) begin
        if (!fr_q[i] && base_q + {16'd0, off_q[i]} == rq.release_address) begin
          pick = i;
          found = 1;
          break;
        end
      end
      if (!found) begin
        r.status = ST_BADADDR;
      end else begin
        r.status = ST_OK;
        fr_q[pick] = 1'b1;
        alloc_q = (alloc_q >= len_q[pick]) ? alloc_q - len_q[pick] : '0;
        if (pick + 1 < used_q && fr_q[pick+1]) begin
          len_q[pick] = len_q[pick] + len_q[pick+1];
          drop_entry(pick + 1);
        end
        if (pick > 0 && fr_q[pick-1]) begin
          len_q[pick-1] = len_q[pick-1] + len_q[pick];
          drop_entry(pick);
        end
      end
    end
    nfree = 0;
    for (int i = 0; i < used_q; i++) if (fr_q[i]) nfree++;
    r.bytes_in_use = alloc_q;
    r.bytes_remaining = (size_q >= alloc_q) ? size_q - alloc_q : '0;
    r.free_segments = nfree[5:0];
    r.grant_count = grants_q;
    return r;
  endfunction

  assign pending_o = rsp_fifo.size();

  always @(posedge clk_i or negedge rst_ni) begin
    fac_rsp_t exp_rsp;
    logic [16:0] sz;
    if (!rst_ni) begin
      base_q = '0;
      size_q = POOL_LIMIT;
      pool_clear();
      rsp_fifo.delete();
      errors_o <= 0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_POOL_BASE || cfg_idx_i == CFG_POOL_SIZE)) begin
        if (cfg_idx_i == CFG_POOL_BASE) begin
          base_q = cfg_data_i;
        end else begin
          sz = cfg_data_i[16:0];
          if (sz == 0) sz = 17'd1;
          if (sz > POOL_LIMIT) sz = POOL_LIMIT;
          size_q = sz;
        end
        pool_clear();
      end
      if (out_valid_i && !out_stall_i) begin
        if (rsp_fifo.size() == 0) begin
          if (errors_o < 10) $display("unexpected response %p", out_rsp_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_rsp = rsp_fifo.pop_front();
          if (out_rsp_i !== exp_rsp) begin
            if (errors_o < 10) $display("mismatch: expected %p got %p", exp_rsp, out_rsp_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) rsp_fifo.push_back(alloc_outcome(in_req_i));
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import fac_pkg::*;

  localparam int RAND_ITEMS = 1830;
  localparam int IDLE_LIMIT = 20000;
  localparam int REQ_W = $bits(fac_req_t);

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  fac_req_t    in_req;
  logic        out_valid;
  logic        out_stall;
  fac_rsp_t    out_rsp;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          idle_cycles;
  bit          calm;
  logic [31:0] granted [$];

  fit_allocator_with_coalescing dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_req_i(in_req), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_rsp_o(out_rsp), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  fac_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .in_req_i(in_req), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_rsp_i(out_rsp), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
        out_stall = 1'b0;
      end
      @(negedge clk);
    end
  end

  task automatic send(logic [1:0] op, logic [16:0] nbytes, logic [31:0] addr);
    if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 10)) @(negedge clk);
    in_req.opcode = op;
    in_req.request_bytes = nbytes;
    in_req.release_address = addr;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    in_req = fac_req_t'(REQ_W'({$urandom, $urandom}));
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_idx = idx;
    cfg_data = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    granted.delete();
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [16:0] pick_size(logic [16:0] psize);
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return psize;
      2: return 17'($urandom_range(0, 17'h1ffff));
      3: return 17'($urandom_range(1, 16));
      default: return 17'($urandom_range(1, (psize > 2000) ? 2000 : psize));
    endcase
  endfunction

  function automatic logic [31:0] chk_guess_next();
    return chk.rsp_fifo.size() != 0 ? chk.rsp_fifo[$].granted_address : 32'd0;
  endfunction

  task automatic random_phase(int n, logic [16:0] psize);
    logic [31:0] a;
    int k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 5) begin
        send(2'($urandom_range(0, 2)), pick_size(psize), $urandom);
        granted.push_back(chk_guess_next());
      end else begin
        if (granted.size() != 0 && $urandom_range(0, 7) != 0) begin
          k = $urandom_range(0, granted.size() - 1);
          a = granted[k];
          if ($urandom_range(0, 5) != 0) granted.delete(k);
        end else begin
          a = (granted.size() != 0 && $urandom_range(0, 1)) ?
              granted[0] + 1 : $urandom;
        end
        send(OP_FREE, 17'($urandom), a);
      end
    end
  endtask

  initial begin
    calm = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send(OP_FIRST, 17'd0, 32'hffffffff);
    send(OP_FIRST, 17'd65536, '0);
    send(OP_FREE, '0, '0);
    send(OP_FIRST, 17'h1ffff, '0);
    send(OP_FREE, 17'h1ffff, 32'hffffffff);
    send(OP_FREE, '0, '0);
    send(OP_FREE, '0, '0);
    send(OP_BEST, 17'd100, '0);
    send(OP_WORST, 17'd200, '0);
    send(OP_FIRST, 17'd1, '0);
    send(OP_FREE, '0, 32'd100);
    send(OP_BEST, 17'd50, '0);
    send(OP_FREE, '0, 32'd301);
    send(OP_FREE, '0, 32'd0);
    send(OP_FREE, '0, 32'd100);
    send(OP_FREE, '0, 32'd100);
    for (int i = 0; i < 33; i++) send(OP_FIRST, 17'd3, '0);
    drain();

    reg_write(CFG_POOL_SIZE, 32'd0);
    send(OP_FIRST, 17'd1, '0);
    send(OP_FIRST, 17'd1, '0);
    reg_write(2'd2, 32'd7);
    reg_write(2'd3, 32'd9);
    send(OP_FREE, '0, '0);
    reg_write(CFG_POOL_BASE, 32'hffffff00);
    reg_write(CFG_POOL_SIZE, 32'hfffe0400);
    random_phase(300, 17'd1024);
    reg_write(CFG_POOL_SIZE, 32'h0001ffff);
    random_phase(300, 17'd65536);
    reg_write(CFG_POOL_BASE, $urandom);
    reg_write(CFG_POOL_SIZE, 32'd200);
    random_phase(300, 17'd200);
    reg_write(CFG_POOL_BASE, 32'd0);
    reg_write(CFG_POOL_SIZE, 32'd65536);
    random_phase(300, 17'd65536);
    reg_write(CFG_POOL_SIZE, $urandom_range(1, 65536));
    random_phase(400, 17'd4096);
    calm = 1;
    random_phase(RAND_ITEMS - 1600, 17'd4096);

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
